@@ sv/swpr_pkg.sv @@
// swpr_pkg: shared codes and controller/datapath interface types for the
// stop-and-wait packet receiver. No dependencies.
`default_nettype none

package swpr_pkg;

    localparam int KIND_W = 3;

    // input packet kinds
    localparam logic [KIND_W-1:0] PK_DATA      = 3'd0;
    localparam logic [KIND_W-1:0] PK_LAST_DATA = 3'd1;
    localparam logic [KIND_W-1:0] PK_ACK       = 3'd2;
    localparam logic [KIND_W-1:0] PK_NACK      = 3'd3;
    localparam logic [KIND_W-1:0] PK_TERM      = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] RK_SEND_ACK  = 3'd0;
    localparam logic [KIND_W-1:0] RK_SEND_NACK = 3'd1;
    localparam logic [KIND_W-1:0] RK_MSG_BYTE  = 3'd2;
    localparam logic [KIND_W-1:0] RK_PEER_ACK  = 3'd3;
    localparam logic [KIND_W-1:0] RK_PEER_NACK = 3'd4;
    localparam logic [KIND_W-1:0] RK_CLOSED    = 3'd5;

    typedef struct packed {
        logic              take_byte;
        logic              capture;
        logic              clr_pkt;
        logic              clr_cnt;
        logic              idx_zero;
        logic              idx_inc;
        logic              rd_en;
        logic              out_load;
        logic [KIND_W-1:0] out_kind;
        logic              out_eom;
        logic              out_last;
    } t_swpr_cmd;

    typedef struct packed {
        logic slot_free;
        logic sum_match;
        logic cnt_zero;
        logic room;
        logic idx_last;
        logic is_last;
    } t_swpr_sts;

endpackage

`default_nettype wire

@@ sv/swpr_ram.sv @@
// swpr_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module swpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/swpr_datapath.sv @@
// swpr_datapath: checksum accumulator, byte staging RAM, drain index and
// output register. Depends on swpr_pkg and swpr_ram.
`default_nettype none

module swpr_datapath #(
    parameter int PAYLOAD_MAX = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire swpr_pkg::t_swpr_cmd         i_cmd,
    output swpr_pkg::t_swpr_sts              o_sts,
    input  wire logic                        i_packet_kind_last,
    input  wire logic signed [7:0]           i_payload_byte,
    input  wire logic signed [31:0]          i_packet_checksum,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [swpr_pkg::KIND_W-1:0]      o_result_kind,
    output logic signed [7:0]                o_message_byte,
    output logic                             o_end_of_message,
    output logic                             o_last_of_run
);
    import swpr_pkg::*;

    localparam int CW = $clog2(PAYLOAD_MAX + 1);
    localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

    logic signed [31:0] r_sum, n_sum;
    logic [1:0]         r_pos;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_idx;
    logic signed [31:0] r_carried;
    logic               r_is_last;
    logic               r_valid;
    logic [7:0]         ram_rdata;

    // contribution of one signed byte
    logic               neg;
    logic [7:0]         mag;
    logic [14:0]        prod;
    logic [5:0]         third;
    logic signed [9:0]  triple;
    logic signed [9:0]  contrib;

    always_comb begin
        neg    = i_payload_byte[7];
        mag    = neg ? 8'(-i_payload_byte) : 8'(i_payload_byte);
        prod   = 15'(mag) * 15'd171;
        third  = prod[14:9];
        triple = 10'(i_payload_byte) + 10'($signed({i_payload_byte, 1'b0}));
        if (r_pos < 2'd2) begin
            contrib = triple;
        end else begin
            contrib = neg ? -10'(third) : 10'(third);
        end
        n_sum = r_sum + 32'(contrib);
    end

    swpr_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_MAX)
    ) u_stage (
        .i_clk   (i_clk),
        .i_we    (i_cmd.take_byte),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_payload_byte),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_pos   <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.clr_pkt) begin
                r_sum <= '0;
                r_pos <= '0;
            end else if (i_cmd.take_byte) begin
                r_sum <= n_sum;
                r_pos <= r_pos + 2'd1;
            end
            if (i_cmd.clr_cnt) begin
                r_count <= '0;
            end else if (i_cmd.take_byte) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.idx_zero) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.out_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_carried <= i_packet_checksum;
            r_is_last <= i_packet_kind_last;
        end
        if (i_cmd.out_load) begin
            o_result_kind    <= i_cmd.out_kind;
            o_message_byte   <= (i_cmd.out_kind == RK_MSG_BYTE) ? ram_rdata : 8'sd0;
            o_end_of_message <= i_cmd.out_eom;
            o_last_of_run    <= i_cmd.out_last;
        end
    end

    assign o_valid = r_valid;

    always_comb begin
        o_sts.slot_free = !r_valid || i_ready;
        o_sts.sum_match = (r_sum == r_carried);
        o_sts.cnt_zero  = (r_count == '0);
        o_sts.room      = (r_count < CW'(PAYLOAD_MAX));
        o_sts.idx_last  = ((r_idx + CW'(1)) == r_count);
        o_sts.is_last   = r_is_last;
    end

endmodule

`default_nettype wire

@@ sv/swpr_ctrl.sv @@
// swpr_ctrl: controller state machine for the stop-and-wait packet receiver.
// Depends on swpr_pkg.
`default_nettype none

module swpr_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [swpr_pkg::KIND_W-1:0] i_packet_kind,
    input  wire logic                        i_byte_present,
    input  wire logic                        i_end_of_packet,
    input  wire swpr_pkg::t_swpr_sts         i_sts,
    output swpr_pkg::t_swpr_cmd              o_cmd
);
    import swpr_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_alive, n_alive;
    logic       accept;
    logic       good;

    assign o_ready = (r_state == ST_IDLE) && i_sts.slot_free;
    assign accept  = i_valid && o_ready;
    assign good    = i_sts.sum_match && !i_sts.cnt_zero;

    always_comb begin
        n_state = r_state;
        n_alive = r_alive;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && r_alive) begin
                    unique case (i_packet_kind)
                        PK_TERM: begin
                            n_alive        = 1'b0;
                            o_cmd.clr_pkt  = 1'b1;
                            o_cmd.clr_cnt  = 1'b1;
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_kind = RK_CLOSED;
                            o_cmd.out_last = 1'b1;
                        end
                        PK_ACK, PK_NACK: begin
                            if (i_end_of_packet) begin
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_kind = (i_packet_kind == PK_ACK) ?
                                                 RK_PEER_ACK : RK_PEER_NACK;
                                o_cmd.out_last = 1'b1;
                            end
                        end
                        PK_DATA, PK_LAST_DATA: begin
                            o_cmd.take_byte = i_byte_present && i_sts.room;
                            if (i_end_of_packet) begin
                                o_cmd.capture = 1'b1;
                                n_state       = ST_CHECK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CHECK: begin
                if (i_sts.slot_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = i_sts.sum_match ? RK_SEND_ACK : RK_SEND_NACK;
                    o_cmd.out_last = !good;
                    o_cmd.clr_pkt  = 1'b1;
                    o_cmd.idx_zero = 1'b1;
                    if (good) begin
                        n_state = ST_READ;
                    end else begin
                        o_cmd.clr_cnt = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.slot_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = RK_MSG_BYTE;
                    o_cmd.out_eom  = i_sts.idx_last && i_sts.is_last;
                    o_cmd.out_last = i_sts.idx_last;
                    if (i_sts.idx_last) begin
                        o_cmd.clr_cnt = 1'b1;
                        n_state       = ST_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = ST_READ;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_alive <= 1'b1;
        end else begin
            r_state <= n_state;
            r_alive <= n_alive;
        end
    end

endmodule

`default_nettype wire

@@ sv/stop_wait_packet_receiver_top.sv @@
// stop_wait_packet_receiver_top: receiving side of a stop-and-wait link.
// Depends on swpr_pkg, swpr_ctrl, swpr_datapath (and swpr_ram through it).
//
// Usage:
//   Input channel (i_valid/o_ready) carries one packet item per transaction:
//   kind, one optional signed payload byte, end-of-packet flag and checksum.
//   Output channel (o_valid/i_ready) carries one result per transaction;
//   o_last_of_run marks the final result caused by an input item.
//   Data bytes are summed and staged in a RAM while it has room. The item
//   that ends a data packet moves the controller to a check state, which
//   loads the ACK/NACK result into the output register once it is free;
//   then each staged byte of a good packet passes a RAM read state and an
//   output load state in turn.
//   Peer ACK/NACK and TERM results are valid the cycle after acceptance.
//   Results pass through a single output register; o_ready is low while a
//   packet is checked or drains, or while that register is full and not
//   being taken. A stalled receiver simply freezes the drain in place.
//   Reset clears the checksum, byte count and reopens the link; no clearing
//   pass is needed. After TERM every item is accepted and dropped until reset.
`default_nettype none

module stop_wait_packet_receiver_top #(
    parameter int PAYLOAD_MAX = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [swpr_pkg::KIND_W-1:0] i_packet_kind,
    input  wire logic signed [7:0]           i_payload_byte,
    input  wire logic                        i_byte_present,
    input  wire logic                        i_end_of_packet,
    input  wire logic signed [31:0]          i_packet_checksum,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [swpr_pkg::KIND_W-1:0]      o_result_kind,
    output logic signed [7:0]                o_message_byte,
    output logic                             o_end_of_message,
    output logic                             o_last_of_run
);
    import swpr_pkg::*;

    t_swpr_cmd cmd;
    t_swpr_sts sts;

    swpr_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_packet_kind   (i_packet_kind),
        .i_byte_present  (i_byte_present),
        .i_end_of_packet (i_end_of_packet),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    swpr_datapath #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_packet_kind_last (i_packet_kind == PK_LAST_DATA),
        .i_payload_byte     (i_payload_byte),
        .i_packet_checksum  (i_packet_checksum),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_result_kind      (o_result_kind),
        .o_message_byte     (o_message_byte),
        .o_end_of_message   (o_end_of_message),
        .o_last_of_run      (o_last_of_run)
    );

endmodule

`default_nettype wire
